>>> rtl/jfss_pkg.sv
// jfss_pkg: shared types, status codes and marker constants for the jpeg frame size scanner
// no dependencies; used by jfss_parser and jpeg_frame_size_scanner

package jfss_pkg;

    // result status codes
    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_NOT_JPEG = 3'd2;
    localparam logic [2:0] ST_NO_FRAME = 3'd3;
    localparam logic [2:0] ST_NOT_JFIF = 3'd4;

    localparam int unsigned MIN_FILE_BYTES = 24;

    // file byte positions of the first-segment size bytes
    localparam int unsigned POS_HEIGHT_HI = 7;
    localparam int unsigned POS_HEIGHT_LO = 8;
    localparam int unsigned POS_WIDTH_HI  = 9;
    localparam int unsigned POS_WIDTH_LO  = 10;
    localparam int unsigned HEADER_BYTES  = 10;

    // frame header: this many bytes including the two marker bytes, size at offsets 5..8
    localparam int unsigned FRAME_SPAN = 12;
    localparam int unsigned FRAME_TAIL = FRAME_SPAN - 2;

    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_APP0   = 8'hE0;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_SOF1   = 8'hC1;
    localparam logic [7:0] MK_SOF2   = 8'hC2;
    localparam logic [7:0] MK_SOF3   = 8'hC3;
    localparam logic [7:0] MK_SOF9   = 8'hC9;
    localparam logic [7:0] MK_SOF10  = 8'hCA;
    localparam logic [7:0] MK_SOF11  = 8'hCB;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_I      = 8'h49;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] height;
        logic [15:0] width;
        logic [31:0] length;
    } t_result;

    function automatic logic is_frame_code(input logic [7:0] code);
        logic hit;
        case (code)
            MK_SOF0, MK_SOF1, MK_SOF2, MK_SOF3,
            MK_SOF9, MK_SOF10, MK_SOF11: hit = 1'b1;
            default:                     hit = 1'b0;
        endcase
        return hit;
    endfunction

    // expected byte of a jfif file header at positions 0..9
    function automatic logic [7:0] want_byte(input logic [3:0] idx);
        logic [7:0] val;
        unique case (idx)
            4'd0:    val = MK_PREFIX;
            4'd1:    val = MK_SOI;
            4'd2:    val = MK_PREFIX;
            4'd3:    val = MK_APP0;
            4'd6:    val = CH_J;
            4'd7:    val = CH_F;
            4'd8:    val = CH_I;
            4'd9:    val = CH_F;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/jpeg_frame_size_scanner.sv
// jpeg_frame_size_scanner: stream top level, input register, parser and result register
// depends on jfss_pkg and jfss_parser
//
// Takes a jpeg file one byte per item, the final byte flagged by tlast, and
// returns one result item for each file: status, frame height, frame width
// and byte count. One input item is taken every clock cycle unless stalled;
// a result item is registered as its final byte is parsed, held until taken.
// Input stalls only while a finished result waits and the next final byte
// is ready to be parsed. The byte counter is LENGTH_BITS wide and saturates;
// the reported length saturates at 2^32-1.

module jpeg_frame_size_scanner #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // image_height, image_width, file_length
    output logic [2:0]  o_m_axis_tuser    // status
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    jfss_pkg::t_result r_result;
    jfss_pkg::t_result w_result;
    logic              w_accept;
    logic              w_advance;
    logic              w_take;

    assign w_advance       = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_take          = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    jfss_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_result <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_result.status;
    assign o_m_axis_tdata  = {r_result.length, r_result.width, r_result.height};

`ifndef NO_ASSERTIONS
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("staged item lost or overwritten");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |-> !(w_advance && r_in_last))
        else $error("result overwritten before taken");

    a_size_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_result.status == jfss_pkg::ST_SHORT ||
                        r_result.status == jfss_pkg::ST_NOT_JPEG ||
                        r_result.status == jfss_pkg::ST_NO_FRAME)
        |-> r_result.height == 16'd0 && r_result.width == 16'd0)
        else $error("size reported on failed scan");

    a_short_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.status != jfss_pkg::ST_SHORT
        |-> r_result.length >= 32'(jfss_pkg::MIN_FILE_BYTES))
        else $error("short file not flagged");
`endif

endmodule

>>> rtl/jfss_parser.sv
// jfss_parser: per-byte header check, segment walk and byte counter, one byte per go pulse
// depends on jfss_pkg; produces the result for the byte flagged last

module jfss_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output jfss_pkg::t_result   o_result
);

    localparam logic [3:0] PH_HEAD  = 4'd0;
    localparam logic [3:0] PH_MARK  = 4'd1;
    localparam logic [3:0] PH_CODE  = 4'd2;
    localparam logic [3:0] PH_LENH  = 4'd3;
    localparam logic [3:0] PH_LENL  = 4'd4;
    localparam logic [3:0] PH_SKIP  = 4'd5;
    localparam logic [3:0] PH_FRAME = 4'd6;
    localparam logic [3:0] PH_FOUND = 4'd7;
    localparam logic [3:0] PH_DEAD  = 4'd8;

    localparam int FLAG_SOI  = 0;
    localparam int FLAG_JFIF = 1;

    localparam logic [15:0] SBL_H_HI = 16'(jfss_pkg::FRAME_SPAN - 5);
    localparam logic [15:0] SBL_H_LO = 16'(jfss_pkg::FRAME_SPAN - 6);
    localparam logic [15:0] SBL_W_HI = 16'(jfss_pkg::FRAME_SPAN - 7);
    localparam logic [15:0] SBL_W_LO = 16'(jfss_pkg::FRAME_SPAN - 8);

    logic [LENGTH_BITS-1:0] r_pos, n_pos;
    logic [3:0]             r_phase, n_phase;
    logic [15:0]            r_sbl, n_sbl;
    logic [7:0]             r_lenh, n_lenh;
    logic [1:0]             r_flags, n_flags;
    logic [15:0]            r_height, n_height;
    logic [15:0]            r_width, n_width;

    logic [15:0]            w_len;
    logic [15:0]            w_dec;
    logic [63:0]            w_count;
    logic [7:0]             w_want;

    always_comb begin
        n_pos    = (&r_pos) ? r_pos : r_pos + 1'b1;
        n_phase  = r_phase;
        n_sbl    = r_sbl;
        n_lenh   = r_lenh;
        n_flags  = r_flags;
        n_height = r_height;
        n_width  = r_width;
        w_len    = {r_lenh, i_byte};
        w_dec    = (r_sbl != 16'd0) ? r_sbl - 16'd1 : r_sbl;
        w_want   = jfss_pkg::want_byte(r_pos[3:0]);

        // fixed jfif header check and first-segment size bytes
        if (r_pos < LENGTH_BITS'(jfss_pkg::HEADER_BYTES)) begin
            if (r_pos < LENGTH_BITS'(3) && i_byte != w_want) begin
                n_flags[FLAG_SOI]  = 1'b1;
                n_flags[FLAG_JFIF] = 1'b1;
            end
            if ((r_pos == LENGTH_BITS'(3) || r_pos >= LENGTH_BITS'(6)) && i_byte != w_want) begin
                n_flags[FLAG_JFIF] = 1'b1;
            end
        end
        if (r_pos == LENGTH_BITS'(jfss_pkg::POS_HEIGHT_HI)) n_height[15:8] = i_byte;
        if (r_pos == LENGTH_BITS'(jfss_pkg::POS_HEIGHT_LO)) n_height[7:0]  = i_byte;
        if (r_pos == LENGTH_BITS'(jfss_pkg::POS_WIDTH_HI))  n_width[15:8]  = i_byte;
        if (r_pos == LENGTH_BITS'(jfss_pkg::POS_WIDTH_LO))  n_width[7:0]   = i_byte;

        // segment walk
        unique case (r_phase)
            PH_HEAD: begin
                if (r_pos != '0) n_phase = PH_MARK;
            end
            PH_MARK: begin
                n_phase = (i_byte == jfss_pkg::MK_PREFIX) ? PH_CODE : PH_DEAD;
            end
            PH_CODE: begin
                if (jfss_pkg::is_frame_code(i_byte)) begin
                    n_phase = PH_FRAME;
                    n_sbl   = 16'(jfss_pkg::FRAME_TAIL);
                end else begin
                    n_phase = PH_LENH;
                end
            end
            PH_LENH: begin
                n_lenh  = i_byte;
                n_phase = PH_LENL;
            end
            PH_LENL: begin
                if (w_len < 16'd2) begin
                    n_phase = PH_DEAD;
                end else if (w_len == 16'd2) begin
                    n_phase = PH_MARK;
                end else begin
                    n_sbl   = w_len - 16'd2;
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_sbl = w_dec;
                if (w_dec == 16'd0) n_phase = PH_MARK;
            end
            PH_FRAME: begin
                if (!n_flags[FLAG_JFIF]) begin
                    if (r_sbl == SBL_H_HI) n_height[15:8] = i_byte;
                    if (r_sbl == SBL_H_LO) n_height[7:0]  = i_byte;
                    if (r_sbl == SBL_W_HI) n_width[15:8]  = i_byte;
                    if (r_sbl == SBL_W_LO) n_width[7:0]   = i_byte;
                end
                n_sbl = w_dec;
                if (w_dec == 16'd0) n_phase = PH_FOUND;
            end
            PH_FOUND, PH_DEAD: begin
            end
            default: begin
                n_phase = PH_DEAD;
            end
        endcase

        // result for a final byte
        w_count         = 64'(n_pos);
        o_result.length = (|w_count[63:32]) ? 32'hFFFF_FFFF : w_count[31:0];
        o_result.height = 16'd0;
        o_result.width  = 16'd0;
        if (n_pos < LENGTH_BITS'(jfss_pkg::MIN_FILE_BYTES)) begin
            o_result.status = jfss_pkg::ST_SHORT;
        end else if (n_flags[FLAG_SOI]) begin
            o_result.status = jfss_pkg::ST_NOT_JPEG;
        end else if (n_flags[FLAG_JFIF]) begin
            o_result.status = jfss_pkg::ST_NOT_JFIF;
            o_result.height = n_height;
            o_result.width  = n_width;
        end else if (n_phase == PH_FOUND) begin
            o_result.status = jfss_pkg::ST_FOUND;
            o_result.height = n_height;
            o_result.width  = n_width;
        end else begin
            o_result.status = jfss_pkg::ST_NO_FRAME;
        end

        // next byte starts a new file
        if (i_last) begin
            n_pos    = '0;
            n_phase  = PH_HEAD;
            n_sbl    = 16'd0;
            n_lenh   = 8'd0;
            n_flags  = 2'd0;
            n_height = 16'd0;
            n_width  = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_phase  <= PH_HEAD;
            r_sbl    <= 16'd0;
            r_lenh   <= 8'd0;
            r_flags  <= 2'd0;
            r_height <= 16'd0;
            r_width  <= 16'd0;
        end else if (i_go) begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_sbl    <= n_sbl;
            r_lenh   <= n_lenh;
            r_flags  <= n_flags;
            r_height <= n_height;
            r_width  <= n_width;
        end
    end

endmodule
